>>> hw/rtl/ehm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder health monitor package
// Payload, configuration and state types shared by the check logic and the
// top level, with register indexes and reset values.
// ---------------------------------------------------------------------------
package ehm_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] CFG_MAX_COUNT_MAGNITUDE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_JUMP             = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FROZEN_TIMEOUT_MS    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ACTIVE_EFFORT_TENTHS = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CONFIRM_CYCLES       = 3'd4;

    localparam logic [30:0] RST_MAX_COUNT_MAGNITUDE  = 31'd65535;
    localparam logic [30:0] RST_MAX_JUMP             = 31'd1000;
    localparam logic [15:0] RST_FROZEN_TIMEOUT_MS    = 16'd500;
    localparam logic [9:0]  RST_ACTIVE_EFFORT_TENTHS = 10'd200;
    localparam logic [7:0]  RST_CONFIRM_CYCLES       = 8'd2;

    localparam logic [7:0] CONFIRM_SAT = 8'd255;

    typedef struct packed {
        logic signed [31:0] encoder_count;
        logic [31:0]        now_ms;
        logic               homing_done;
        logic [9:0]         effort_tenths;
    } t_ehm_in;

    typedef struct packed {
        logic fault;
        logic rebaselined;
    } t_ehm_out;

    typedef struct packed {
        logic [30:0] max_count_magnitude;
        logic [30:0] max_jump;
        logic [15:0] frozen_timeout_ms;
        logic [9:0]  active_effort_tenths;
        logic [7:0]  confirm_cycles;
    } t_ehm_cfg;

    typedef struct packed {
        logic               fault_latch;
        logic signed [31:0] previous_count;
        logic [31:0]        last_change_time;
        logic [7:0]         frozen_confirm_count;
        logic               centering_was_done;
    } t_ehm_state;

endpackage
`default_nettype wire

>>> hw/rtl/ehm_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder health check
// One check per transaction: rebaseline on centering, range, jump and frozen
// detection. Produces the next monitor state and the result.
// ---------------------------------------------------------------------------
module ehm_check (
    input  wire ehm_pkg::t_ehm_in    i_item,
    input  wire ehm_pkg::t_ehm_cfg   i_cfg,
    input  wire ehm_pkg::t_ehm_state i_state,
    output ehm_pkg::t_ehm_state      o_state,
    output ehm_pkg::t_ehm_out        o_result
);
    import ehm_pkg::*;

    logic        rebase;
    logic [32:0] count_ext;
    logic [32:0] count_mag;
    logic [32:0] delta;
    logic [32:0] delta_mag;
    logic        range_bad;
    logic        jump_bad;
    logic        moving;
    logic [31:0] elapsed;
    logic        timed_out;
    logic [7:0]  cnt_inc;
    logic        latch;

    always_comb begin
        rebase    = i_item.homing_done && !i_state.centering_was_done
                    && !i_state.fault_latch;
        count_ext = {i_item.encoder_count[31], i_item.encoder_count};
        count_mag = count_ext[32] ? (33'd0 - count_ext) : count_ext;
        range_bad = count_mag > {2'b00, i_cfg.max_count_magnitude};

        delta     = count_ext - {i_state.previous_count[31], i_state.previous_count};
        delta_mag = delta[32] ? (33'd0 - delta) : delta;
        jump_bad  = delta_mag > {2'b00, i_cfg.max_jump};

        moving    = (i_item.encoder_count != i_state.previous_count)
                    || (i_item.effort_tenths <= i_cfg.active_effort_tenths);
        elapsed   = i_item.now_ms - i_state.last_change_time;
        timed_out = elapsed > {16'd0, i_cfg.frozen_timeout_ms};
        cnt_inc   = (i_state.frozen_confirm_count == CONFIRM_SAT)
                    ? CONFIRM_SAT : i_state.frozen_confirm_count + 8'd1;
        latch     = 1'b0;

        o_state = i_state;
        if (rebase) begin
            o_state.previous_count       = i_item.encoder_count;
            o_state.last_change_time     = i_item.now_ms;
            o_state.frozen_confirm_count = 8'd0;
            o_state.centering_was_done   = 1'b1;
        end else begin
            o_state.centering_was_done = i_item.homing_done;
            if (!i_state.fault_latch) begin
                if (range_bad || jump_bad) begin
                    o_state.fault_latch = 1'b1;
                end else begin
                    if (moving) begin
                        // restart the frozen window
                        o_state.last_change_time     = i_item.now_ms;
                        o_state.frozen_confirm_count = 8'd0;
                    end else if (timed_out) begin
                        o_state.frozen_confirm_count = cnt_inc;
                        latch = cnt_inc >= i_cfg.confirm_cycles;
                    end
                    if (latch) begin
                        o_state.fault_latch = 1'b1;
                    end else begin
                        o_state.previous_count = i_item.encoder_count;
                    end
                end
            end
        end

        o_result.fault       = rebase ? 1'b0 : o_state.fault_latch;
        o_result.rebaselined = rebase;
    end

endmodule
`default_nettype wire

>>> hw/rtl/encoder_health_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Encoder health monitor
// Steering encoder plausibility checks with a latched fault output.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------
//  input    | i_in_valid / o_in_ready    | i_in  (t_ehm_in)
//  result   | o_out_valid / i_out_ready  | o_out (t_ehm_out)
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  Each transaction passes an input register and then a result register;
//  one transaction is accepted every cycle while the result channel does
//  not stall.
//  The monitor state updates when a check moves into the result register.
//  Reset clears the state and loads the register defaults; no clearing pass.
//  A stalled result holds in its register; the input register still fills if it is empty.
// ---------------------------------------------------------------------------
module encoder_health_monitor (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire ehm_pkg::t_ehm_in          i_in,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output ehm_pkg::t_ehm_out              o_out,
    input  wire                            i_cfg_we,
    input  wire [ehm_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire [ehm_pkg::CfgDataW-1:0]    i_cfg_data
);
    import ehm_pkg::*;

    t_ehm_cfg   r_cfg;
    t_ehm_state r_state;
    t_ehm_state n_state;
    logic       r_in_valid;
    t_ehm_in    r_in;
    logic       r_out_valid;
    t_ehm_out   r_out;
    t_ehm_out   n_out;
    logic       out_free;
    logic       advance;

    ehm_check u_check (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        advance     = r_in_valid && out_free;
        o_in_ready  = !r_in_valid || advance;
        o_out_valid = r_out_valid;
        o_out       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_count_magnitude  <= RST_MAX_COUNT_MAGNITUDE;
            r_cfg.max_jump             <= RST_MAX_JUMP;
            r_cfg.frozen_timeout_ms    <= RST_FROZEN_TIMEOUT_MS;
            r_cfg.active_effort_tenths <= RST_ACTIVE_EFFORT_TENTHS;
            r_cfg.confirm_cycles       <= RST_CONFIRM_CYCLES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_COUNT_MAGNITUDE:  r_cfg.max_count_magnitude  <= i_cfg_data;
                CFG_MAX_JUMP:             r_cfg.max_jump             <= i_cfg_data;
                CFG_FROZEN_TIMEOUT_MS:    r_cfg.frozen_timeout_ms    <= i_cfg_data[15:0];
                CFG_ACTIVE_EFFORT_TENTHS: r_cfg.active_effort_tenths <= i_cfg_data[9:0];
                CFG_CONFIRM_CYCLES:       r_cfg.confirm_cycles       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
